// File: design/oat_pkg.sv
// Package for the ordered array table: sizes, opcode and status codes,
// and the per-cell operation code. No dependencies.
`default_nettype none

package oat_pkg;

    localparam int DEPTH  = 32;
    localparam int DATA_W = 32;

    // fixed transaction field widths
    localparam int OPC_W  = 3;
    localparam int POS_W  = 6;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 3;
    localparam int RIDX_W = 5;
    localparam int RCNT_W = 6;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // common width for position versus count compares
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OPC_W-1:0] {
        OP_DUMP   = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_UPDATE = 3'd4,
        OP_COUNT  = 3'd5
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_MISS   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT,
        CELL_FROM_HEAD
    } cell_op_t;

endpackage

`default_nettype wire

// File: design/oat_ifs.sv
// Valid/ready channel interfaces for commands and responses.
// Depends on oat_pkg for field widths.
`default_nettype none

interface oat_cmd_if;
    import oat_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPC_W-1:0]        opcode;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, opcode, position, value, input ready);
    modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface oat_rsp_if;
    import oat_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STAT_W-1:0]       status;
    logic [RIDX_W-1:0]       index;
    logic signed [VAL_W-1:0] data;
    logic [RCNT_W-1:0]       count;
    logic                    last;

    modport source (output valid, status, index, data, count, last, input ready);
    modport sink   (input valid, status, index, data, count, last, output ready);
endinterface

`default_nettype wire

// File: design/oat_cell.sv
// One table cell: holds a single entry, takes data from a neighbor,
// the key or the head cell, and flags a match against the key.
// Depends on oat_pkg.
`default_nettype none

module oat_cell (
    input  wire logic                      clk,
    input  oat_pkg::cell_op_t              op,
    input  wire logic [oat_pkg::DATA_W-1:0] key,
    input  wire logic [oat_pkg::DATA_W-1:0] left,
    input  wire logic [oat_pkg::DATA_W-1:0] right,
    input  wire logic [oat_pkg::DATA_W-1:0] head,
    output logic      [oat_pkg::DATA_W-1:0] q,
    output logic                           match
);
    import oat_pkg::*;

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        unique case (op)
            CELL_HOLD:       entry_next = entry_reg;
            CELL_LOAD:       entry_next = key;
            CELL_FROM_LEFT:  entry_next = left;
            CELL_FROM_RIGHT: entry_next = right;
            CELL_FROM_HEAD:  entry_next = head;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q     = entry_reg;
    assign match = (entry_reg == key);

endmodule

`default_nettype wire

// File: design/oat_seq.sv
// Command sequencer: decodes transactions, drives the cell operations,
// keeps the fill count and the response register. Depends on oat_pkg
// and the channel interfaces.
`default_nettype none

module oat_seq (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    oat_cmd_if.sink                         cmd,
    oat_rsp_if.source                       rsp,
    input  wire logic [oat_pkg::DATA_W-1:0] head,
    input  wire logic [oat_pkg::DEPTH-1:0]  match,
    output logic      [oat_pkg::DATA_W-1:0] key,
    output oat_pkg::cell_op_t               cell_op [oat_pkg::DEPTH]
);
    import oat_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DUMP
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [DATA_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]    dump_idx_reg, dump_idx_next;

    logic                rsp_valid_reg, rsp_valid_next;
    status_t             status_reg, status_next;
    logic [IDX_W-1:0]    index_reg, index_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                accept;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    fill_ext;
    logic [DEPTH-1:0]    hits;
    logic [IDX_W-1:0]    hit_idx;
    logic                dump_last;

    logic                r_load;
    status_t             r_status;
    logic [IDX_W-1:0]    r_index;
    logic [DATA_W-1:0]   r_data;

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign pos_ext   = CMP_W'(cmd.position);
    assign fill_ext  = CMP_W'(fill_reg);
    assign key       = (state_reg == S_IDLE) ? cmd.value[DATA_W-1:0] : key_reg;
    assign dump_last = (CNT_W'(dump_idx_reg) + CNT_W'(1)) == fill_reg;

    // only held entries take part; the lowest hit wins
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hits[i] = match[i] && (CNT_W'(i) < fill_reg);
        end
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        key_next      = key_reg;
        dump_idx_next = dump_idx_reg;
        r_load        = 1'b0;
        r_status      = ST_OK;
        r_index       = '0;
        r_data        = '0;
        last_next     = last_reg;
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_op[i] = CELL_HOLD;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    r_load    = 1'b1;
                    last_next = 1'b1;
                    unique case (cmd.opcode)
                        OP_DUMP:
                        begin
                            if (fill_reg == '0)
                            begin
                                r_status = ST_EMPTY;
                            end
                            else
                            begin
                                r_load        = 1'b0;
                                dump_idx_next = '0;
                                state_next    = S_DUMP;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (fill_reg == CNT_W'(DEPTH))
                            begin
                                r_status = ST_FULL;
                            end
                            else if (pos_ext > fill_ext)
                            begin
                                r_status = ST_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) == pos_ext)
                                    begin
                                        cell_op[i] = CELL_LOAD;
                                    end
                                    else if (CMP_W'(i) > pos_ext)
                                    begin
                                        cell_op[i] = CELL_FROM_LEFT;
                                    end
                                end
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (fill_reg == '0)
                            begin
                                r_status = ST_EMPTY;
                            end
                            else if (pos_ext >= fill_ext)
                            begin
                                r_status = ST_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) >= pos_ext)
                                    begin
                                        cell_op[i] = CELL_FROM_RIGHT;
                                    end
                                end
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                r_status = ST_EMPTY;
                            end
                            else
                            begin
                                r_load     = 1'b0;
                                key_next   = cmd.value[DATA_W-1:0];
                                state_next = S_SEARCH;
                            end
                        end
                        OP_UPDATE:
                        begin
                            if (fill_reg == '0)
                            begin
                                r_status = ST_EMPTY;
                            end
                            else if (pos_ext >= fill_ext)
                            begin
                                r_status = ST_BADPOS;
                            end
                            else
                            begin
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    if (CMP_W'(i) == pos_ext)
                                    begin
                                        cell_op[i] = CELL_LOAD;
                                    end
                                end
                            end
                        end
                        OP_COUNT:
                        begin
                            r_status = ST_OK;
                        end
                        default:
                        begin
                            r_status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (out_free)
                begin
                    r_load     = 1'b1;
                    last_next  = 1'b1;
                    r_status   = (|hits) ? ST_OK : ST_MISS;
                    r_index    = hit_idx;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                // emit the head, then rotate the held entries left by one;
                // after fill_count steps the table is back in order
                if (out_free)
                begin
                    r_load    = 1'b1;
                    last_next = dump_last;
                    r_index   = dump_idx_reg;
                    r_data    = head;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if ((CNT_W'(i) + CNT_W'(1)) < fill_reg)
                        begin
                            cell_op[i] = CELL_FROM_RIGHT;
                        end
                        else if ((CNT_W'(i) + CNT_W'(1)) == fill_reg)
                        begin
                            cell_op[i] = CELL_FROM_HEAD;
                        end
                    end
                    dump_idx_next = dump_idx_reg + IDX_W'(1);
                    if (dump_last)
                    begin
                        dump_idx_next = '0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        index_next     = index_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        if (r_load)
        begin
            rsp_valid_next = 1'b1;
            status_next    = r_status;
            index_next     = r_index;
            data_next      = r_data;
            count_next     = fill_next;
        end
        else
        begin
            last_next = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            key_reg       <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            index_reg     <= '0;
            data_reg      <= '0;
            count_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            key_reg       <= key_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            index_reg     <= index_next;
            data_reg      <= data_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
        end
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.index  = RIDX_W'(index_reg);
    assign rsp.data   = VAL_W'(data_reg);
    assign rsp.count  = RCNT_W'(count_reg);
    assign rsp.last   = last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 (fill_reg == $past(fill_reg) || fill_reg == $past(fill_reg) + CNT_W'(1)
             || fill_reg == $past(fill_reg) - CNT_W'(1)))
        else $error("fill count moved by more than one");

    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.opcode == OP_INSERT && fill_reg == CNT_W'(DEPTH))
        |=> (fill_reg == CNT_W'(DEPTH) && rsp.valid && rsp.status == ST_FULL))
        else $error("insert into full table not rejected");

    a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP && out_free && dump_last)
        |=> (state_reg == S_IDLE && rsp.valid && rsp.last))
        else $error("dump run did not close with last");

    a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(fill_reg))
        else $error("fill count changed during search or dump");

endmodule

`default_nettype wire

// File: design/ordered_array_table_core.sv
// Ordered array table: one command per cycle for insert, delete, update, count
// unless responses stall; result registered the cycle after acceptance. Search:
// key registered, then compare in all cells, lowest-index select. Dump: fill_count
// results, one per cycle unless responses stall, the first once in the dump
// state; the cell chain rotates once per result. Reset clears the fill count and
// control; entries hold no reset value and are never read above the fill count.
// Depends on oat_pkg, oat_ifs, oat_cell, oat_seq.
`default_nettype none

module ordered_array_table_core (
    input  wire logic clk,
    input  wire logic rst_n,
    oat_cmd_if.sink   cmd,
    oat_rsp_if.source rsp
);
    import oat_pkg::*;

    logic [DATA_W-1:0] q     [DEPTH];
    logic [DEPTH-1:0]  match;
    logic [DATA_W-1:0] key;
    cell_op_t          cell_op [DEPTH];

    oat_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .head    (q[0]),
        .match   (match),
        .key     (key),
        .cell_op (cell_op)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        oat_cell u_cell (
            .clk   (clk),
            .op    (cell_op[i]),
            .key   (key),
            .left  ((i == 0) ? key : q[(i == 0) ? 0 : i - 1]),
            .right ((i == DEPTH - 1) ? q[i] : q[(i == DEPTH - 1) ? i : i + 1]),
            .head  (q[0]),
            .q     (q[i]),
            .match (match[i])
        );
    end

endmodule

`default_nettype wire

// File: dv/ordered_array_table_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ordered_array_table_core: insert, delete, search,
// update, count and dump commands checked against an in-bench table model.
// Depends on oat_pkg, oat_ifs and the core RTL.

module ordered_array_table_core_test;
    import oat_pkg::*;

    localparam logic [OPC_W-1:0] OP_UNUSED6 = 3'd6;
    localparam logic [OPC_W-1:0] OP_UNUSED7 = 3'd7;
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 49;
    localparam int POOL_SIZE     = 8;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RIDX_W-1:0] index;
        logic [VAL_W-1:0]  data;
        logic [RCNT_W-1:0] count;
        logic              last;
    } rsp_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    oat_cmd_if cmd_ch ();
    oat_rsp_if rsp_ch ();

    ordered_array_table_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // driven registers, known from time zero
    logic      drv_valid   = 1'b0;
    cmd_item_t drv_item    = '0;
    logic      rsp_ready_q = 1'b0;

    assign cmd_ch.valid    = drv_valid;
    assign cmd_ch.opcode   = drv_item.opcode;
    assign cmd_ch.position = drv_item.position;
    assign cmd_ch.value    = drv_item.value;
    assign rsp_ch.ready    = rsp_ready_q;

    cmd_item_t pending_cmds [$];
    rsp_item_t expected_rsp [$];
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        mismatch_count = 0;

    // table model
    logic [DATA_W-1:0] tbl_cells [DEPTH];
    int unsigned       tbl_fill = 0;

    // stimulus-side view of the fill count, used to aim positions
    int unsigned       gen_fill    = 0;
    bit                gen_growing = 1'b1;
    logic [VAL_W-1:0]  value_pool [POOL_SIZE];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cmd_item_t mk_cmd(logic [OPC_W-1:0] op, int pos, logic [VAL_W-1:0] val);
        cmd_item_t c;
        c.opcode   = op;
        c.position = POS_W'(pos);
        c.value    = val;
        return c;
    endfunction

    task automatic push_result(logic [STAT_W-1:0] st, int idx, logic [VAL_W-1:0] dat,
                               logic lst);
        rsp_item_t r;
        r.status = st;
        r.index  = RIDX_W'(idx);
        r.data   = dat;
        r.count  = RCNT_W'(tbl_fill);
        r.last   = lst;
        expected_rsp.push_back(r);
    endtask

    task automatic table_apply(cmd_item_t c);
        int unsigned p;
        int          hit;
        p   = 32'(c.position);
        hit = -1;
        case (c.opcode)
            OP_DUMP:
                if (tbl_fill == 0)
                    push_result(ST_EMPTY, 0, '0, 1'b1);
                else
                    for (int i = 0; i < tbl_fill; i++)
                        push_result(ST_OK, i, tbl_cells[i], (i + 1 == tbl_fill));
            OP_INSERT:
                if (tbl_fill >= DEPTH)
                    push_result(ST_FULL, 0, '0, 1'b1);
                else if (p > tbl_fill)
                    push_result(ST_BADPOS, 0, '0, 1'b1);
                else
                begin
                    for (int i = tbl_fill; i > p; i--)
                        tbl_cells[i] = tbl_cells[i-1];
                    tbl_cells[p] = c.value;
                    tbl_fill++;
                    push_result(ST_OK, 0, '0, 1'b1);
                end
            OP_DELETE:
                if (tbl_fill == 0)
                    push_result(ST_EMPTY, 0, '0, 1'b1);
                else if (p >= tbl_fill)
                    push_result(ST_BADPOS, 0, '0, 1'b1);
                else
                begin
                    for (int i = p; i + 1 < tbl_fill; i++)
                        tbl_cells[i] = tbl_cells[i+1];
                    tbl_fill--;
                    push_result(ST_OK, 0, '0, 1'b1);
                end
            OP_SEARCH:
                if (tbl_fill == 0)
                    push_result(ST_EMPTY, 0, '0, 1'b1);
                else
                begin
                    for (int i = tbl_fill - 1; i >= 0; i--)
                        if (tbl_cells[i] == c.value)
                            hit = i;
                    if (hit < 0)
                        push_result(ST_MISS, 0, '0, 1'b1);
                    else
                        push_result(ST_OK, hit, '0, 1'b1);
                end
            OP_UPDATE:
                if (tbl_fill == 0)
                    push_result(ST_EMPTY, 0, '0, 1'b1);
                else if (p >= tbl_fill)
                    push_result(ST_BADPOS, 0, '0, 1'b1);
                else
                begin
                    tbl_cells[p] = c.value;
                    push_result(ST_OK, 0, '0, 1'b1);
                end
            OP_COUNT:
                push_result(ST_OK, 0, '0, 1'b1);
            default:
                push_result(ST_BADPOS, 0, '0, 1'b1);
        endcase
    endtask

    // Random command biased to sweep the fill level between empty and full,
    // with values mostly from a small pool so searches hit and duplicates occur.
    function automatic cmd_item_t make_random_cmd();
        int               r;
        logic [OPC_W-1:0] op;
        int               pos;
        logic [VAL_W-1:0] val;
        r = $urandom_range(99);
        if (r < 55)
            op = gen_growing ? OP_INSERT : OP_DELETE;
        else if (r < 65)
            op = gen_growing ? OP_DELETE : OP_INSERT;
        else if (r < 77)
            op = OP_SEARCH;
        else if (r < 87)
            op = OP_UPDATE;
        else if (r < 92)
            op = OP_COUNT;
        else if (r < 97)
            op = OP_DUMP;
        else
            op = ($urandom_range(1) != 0) ? OP_UNUSED7 : OP_UNUSED6;

        if ($urandom_range(99) < 15)
            pos = $urandom_range(63);
        else if (op == OP_INSERT)
            pos = $urandom_range(gen_fill);
        else if ((op == OP_DELETE || op == OP_UPDATE) && gen_fill > 0)
            pos = $urandom_range(gen_fill - 1);
        else
            pos = $urandom_range(63);

        if ($urandom_range(99) < 65 && (op == OP_INSERT || op == OP_UPDATE || op == OP_SEARCH))
            val = value_pool[$urandom_range(POOL_SIZE - 1)];
        else
            val = $urandom;

        if (op == OP_INSERT && gen_fill < DEPTH && pos <= gen_fill)
            gen_fill++;
        else if (op == OP_DELETE && gen_fill > 0 && pos < gen_fill)
            gen_fill--;

        if (gen_growing && gen_fill == DEPTH && $urandom_range(2) == 0)
            gen_growing = 1'b0;
        else if (!gen_growing && gen_fill == 0 && $urandom_range(2) == 0)
            gen_growing = 1'b1;

        return mk_cmd(op, pos, val);
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_item  <= '0;
        end
        else
        begin
            if (drv_valid && cmd_ch.ready)
                table_apply(drv_item);
            if (!drv_valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drv_item  <= pending_cmds.pop_front();
                    drv_valid <= 1'b1;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // response monitor and ready generator
    always @(posedge clk or negedge rst_n)
    begin : rsp_monitor
        rsp_item_t got;
        rsp_item_t want;
        if (!rst_n)
            rsp_ready_q <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.index  = rsp_ch.index;
                got.data   = rsp_ch.data;
                got.count  = rsp_ch.count;
                got.last   = rsp_ch.last;
                if (expected_rsp.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected response status=%0d index=%0d data=%h %s%0d %s%0b",
                                 $realtime, got.status, got.index, got.data,
                                 "count=", got.count, "last=", got.last);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("%0t: response mismatch", $realtime);
                            $display("    exp status=%0d index=%0d data=%h count=%0d last=%0b",
                                     want.status, want.index, want.data, want.count,
                                     want.last);
                            $display("    got status=%0d index=%0d data=%h count=%0d last=%0b",
                                     got.status, got.index, got.data, got.count,
                                     got.last);
                        end
                    end
                end
            end
            rsp_ready_q <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // sender holds off until every outstanding response is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || drv_valid || expected_rsp.size() != 0);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
            pending_cmds.push_back(make_random_cmd());
        wait_drained();
    endtask

    initial
    begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-table errors, unused opcodes, ends and middle, hits and misses
        pending_cmds.push_back(mk_cmd(OP_DUMP,    0,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_DELETE,  0,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_SEARCH,  0,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_UPDATE,  0,  32'h1));
        pending_cmds.push_back(mk_cmd(OP_COUNT,   63, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_UNUSED6, 0,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_UNUSED7, 63, 32'hFFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  1,  32'h1234_5678));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  0,  32'h7FFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  1,  32'h8000_0000));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  0,  32'hFFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  1,  32'h0000_0000));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  63, 32'h5555_5555));
        pending_cmds.push_back(mk_cmd(OP_INSERT,  32, 32'hAAAA_AAAA));
        pending_cmds.push_back(mk_cmd(OP_SEARCH,  0,  32'h8000_0000));
        pending_cmds.push_back(mk_cmd(OP_SEARCH,  0,  32'h0001_2345));
        pending_cmds.push_back(mk_cmd(OP_UPDATE,  4,  32'h1));
        pending_cmds.push_back(mk_cmd(OP_UPDATE,  3,  32'hFFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_SEARCH,  0,  32'hFFFF_FFFF));
        pending_cmds.push_back(mk_cmd(OP_DUMP,    0,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_DELETE,  4,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_DELETE,  3,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_DELETE,  0,  32'h0));
        pending_cmds.push_back(mk_cmd(OP_UPDATE,  0,  32'h5555_5555));
        pending_cmds.push_back(mk_cmd(OP_DUMP,    0,  32'h0));
        gen_fill = 2;
        wait_drained();

        run_random_phase(0, 0);
        run_random_phase(59, 0);
        run_random_phase(0, 59);
        run_random_phase(13, 13);

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
